// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TAG_W     = 32;
    localparam int PRIO_W    = 8;
    localparam int OCC_W     = 5;

    localparam logic [PRIO_W-1:0] INS_PRIO = PRIO_W'(1);

    typedef enum logic [1:0] {
        ACT_FRONT  = 2'd0,
        ACT_BACK   = 2'd1,
        ACT_SORTED = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
    } req_t;

    typedef struct packed {
        logic [TAG_W-1:0]    front_tag;
        logic [PRIO_W-1:0]   front_prio;
        logic [TAG_W-1:0]    back_tag;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        logic                removed;
        logic                overflow;
    } res_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
    } ent_t;

    typedef struct packed {
        logic                ins;
        logic                rem;
        action_t             action;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry and loads it from the request, from its
// left neighbor or from its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  spq_pkg::cell_ctl_t      ctl,
    input  spq_pkg::ent_t           left,
    input  spq_pkg::ent_t           right,
    input  wire logic               seen_in,
    output logic                    seen_out,
    output spq_pkg::ent_t           ent
);
    import spq_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [PRIO_W-1:0]  prio_reg;
    logic [PRIO_W-1:0]  prio_next;
    logic               stop;
    logic               load_new;
    logic               take_left;
    logic               take_right;
    logic [PRIO_W-1:0]  new_prio;

    always_comb
    begin
        if (ctl.rem)
        begin
            stop = valid_reg && (tag_reg == ctl.tag);
        end
        else
        begin
            case (ctl.action)
                ACT_FRONT:  stop = 1'b1;
                ACT_BACK:   stop = !valid_reg;
                ACT_SORTED: stop = !valid_reg || !(ctl.prio < prio_reg);
                default:    stop = 1'b0;
            endcase
        end
    end

    assign seen_out   = seen_in | stop;
    assign load_new   = ctl.ins & stop & !seen_in;
    assign take_left  = ctl.ins & seen_in;
    assign take_right = ctl.rem & (stop | seen_in);
    assign new_prio   = (ctl.action == ACT_SORTED) ? ctl.prio : INS_PRIO;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        if (load_new)
        begin
            tag_next  = ctl.tag;
            prio_next = new_prio;
        end
        else if (take_left)
        begin
            tag_next  = left.tag;
            prio_next = left.prio;
        end
        else if (take_right)
        begin
            tag_next  = right.tag;
            prio_next = right.prio;
        end
        if (ctl.ins)
        begin
            valid_next = valid_reg | left.valid;
        end
        else if (take_right)
        begin
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign ent = '{valid: valid_reg, tag: tag_reg, prio: prio_reg};

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ordered queue of DEPTH tag/priority entries built as a row of cells.
// ----------------------------------------------------------------------------
// The queue takes one request per cycle while the result side keeps up. On
// acceptance every cell compares its own entry and shifts in parallel into its
// register; then the front and back entries of the updated row and the
// occupancy count are loaded into the result register once it is free. A
// stalled result holds one request in flight before req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  spq_pkg::req_t   req,
    output logic            res_valid,
    input  wire logic       res_stall,
    output spq_pkg::res_t   res
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    ent_t                ents [DEPTH];
    logic [DEPTH:0]      seen;
    logic [DEPTH-1:0]    last;
    cell_ctl_t           ctl;

    logic                accept;
    logic                full;
    logic                out_load;
    logic [TAG_W-1:0]    back_tag;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic                pend_removed_reg;
    logic                pend_removed_next;
    logic                pend_overflow_reg;
    logic                pend_overflow_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    res_t                res_reg;
    res_t                res_next;

    assign accept   = req_valid & !req_stall;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign out_load = pend_valid_reg & (!res_valid_reg | !res_stall);
    assign req_stall = pend_valid_reg & !out_load;

    assign ctl.ins    = accept & (req.action != ACT_REMOVE) & !full;
    assign ctl.rem    = accept & (req.action == ACT_REMOVE);
    assign ctl.action = req.action;
    assign ctl.tag    = req.tag;
    assign ctl.prio   = req.prio;

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            ent_t left_ent;
            ent_t right_ent;

            if (gi == 0)
            begin : g_first
                assign left_ent = '{valid: 1'b1, tag: '0, prio: '0};
            end
            else
            begin : g_mid_l
                assign left_ent = ents[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_ent = '0;
                assign last[gi]  = ents[gi].valid;
            end
            else
            begin : g_mid_r
                assign right_ent = ents[gi+1];
                assign last[gi]  = ents[gi].valid & !ents[gi+1].valid;
            end

            spq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .left     (left_ent),
                .right    (right_ent),
                .seen_in  (seen[gi]),
                .seen_out (seen[gi+1]),
                .ent      (ents[gi])
            );
        end
    endgenerate

    always_comb
    begin
        back_tag = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_tag = back_tag | (ents[i].tag & {TAG_W{last[i]}});
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.rem && seen[DEPTH])
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        pend_valid_next    = accept | (pend_valid_reg & !out_load);
        pend_removed_next  = pend_removed_reg;
        pend_overflow_next = pend_overflow_reg;
        if (accept)
        begin
            pend_removed_next  = ctl.rem & seen[DEPTH];
            pend_overflow_next = (req.action != ACT_REMOVE) & full;
        end
        res_valid_next = out_load | (res_valid_reg & res_stall);
    end

    always_comb
    begin
        res_next = res_reg;
        if (out_load)
        begin
            res_next.front_tag  = ents[0].valid ? ents[0].tag : '0;
            res_next.front_prio = ents[0].valid ? ents[0].prio : '0;
            res_next.back_tag   = back_tag;
            res_next.occupancy  = OCC_W'(count_reg);
            res_next.is_empty   = !ents[0].valid;
            res_next.removed    = pend_removed_reg;
            res_next.overflow   = pend_overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            pend_valid_reg    <= 1'b0;
            pend_removed_reg  <= 1'b0;
            pend_overflow_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            pend_valid_reg    <= pend_valid_next;
            pend_removed_reg  <= pend_removed_next;
            pend_overflow_reg <= pend_overflow_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue.
// A scoreboard class keeps its own copy of the queue and works out the
// front, back, occupancy and flags for every accepted request. Each result
// is compared against the oldest prediction. Directed requests cover the
// empty queue, both inserts at priority one, sorted inserts with ties and
// extreme priorities, first-match and missed removes, and a full queue.
// Random traffic follows in four idle/stall mixes, then a long result
// hold-off fills the queue pipeline until the request side stalls.
// ----------------------------------------------------------------------------

module testbench;

    import spq_pkg::*;

    localparam int QDEPTH         = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    class spq_scoreboard;
        logic [TAG_W-1:0]  tags [QDEPTH];
        logic [PRIO_W-1:0] prios[QDEPTH];
        int                count;
        res_t              expected[$];
        int                errors;
        int                requests;
        int                checked;
        int                hits;
        int                drops;
        int                peak;

        function void note_request(req_t r);
            res_t e;
            int   pos;
            int   i;
            e = '0;
            requests++;
            if (r.action == ACT_REMOVE) begin
                pos = 0;
                while (pos < count && tags[pos] != r.tag)
                    pos++;
                if (pos < count) begin
                    for (i = pos; i < count - 1; i++)
                    begin
                        tags[i]  = tags[i + 1];
                        prios[i] = prios[i + 1];
                    end
                    count--;
                    e.removed = 1'b1;
                    hits++;
                end
            end
            else if (count >= QDEPTH) begin
                e.overflow = 1'b1;
                drops++;
            end
            else begin
                case (r.action)
                    ACT_FRONT: pos = 0;
                    ACT_BACK:  pos = count;
                    default:
                    begin
                        pos = 0;
                        while (pos < count && r.prio < prios[pos])
                            pos++;
                    end
                endcase
                for (i = count; i > pos; i--)
                begin
                    tags[i]  = tags[i - 1];
                    prios[i] = prios[i - 1];
                end
                tags[pos]  = r.tag;
                prios[pos] = (r.action == ACT_SORTED) ? r.prio : INS_PRIO;
                count++;
            end
            if (count > 0) begin
                e.front_tag  = tags[0];
                e.front_prio = prios[0];
                e.back_tag   = tags[count - 1];
            end
            e.occupancy = OCC_W'(count);
            e.is_empty  = (count == 0);
            if (count > peak)
                peak = count;
            expected.push_back(e);
        endfunction

        function void cmp_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t e;
            if (expected.size() == 0) begin
                $error("result with no pending request: %0h", got);
                errors++;
                return;
            end
            e = expected.pop_front();
            checked++;
            cmp_field("front_tag",  e.front_tag,  got.front_tag);
            cmp_field("front_prio", TAG_W'(e.front_prio), TAG_W'(got.front_prio));
            cmp_field("back_tag",   e.back_tag,   got.back_tag);
            cmp_field("occupancy",  TAG_W'(e.occupancy),  TAG_W'(got.occupancy));
            cmp_field("is_empty",   TAG_W'(e.is_empty),   TAG_W'(got.is_empty));
            cmp_field("removed",    TAG_W'(e.removed),    TAG_W'(got.removed));
            cmp_field("overflow",   TAG_W'(e.overflow),   TAG_W'(got.overflow));
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  res_valid;
    logic  res_stall;
    res_t  res;

    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_start;

    spq_scoreboard sb;

    sorted_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    function automatic req_t make_req(action_t a, logic [TAG_W-1:0] t, logic [PRIO_W-1:0] p);
        req_t r;
        r.action = a;
        r.tag    = t;
        r.prio   = p;
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2, 3:    return $urandom();
            default: return TAG_W'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return INS_PRIO;
            3, 4:    return PRIO_W'($urandom_range(3));
            default: return PRIO_W'($urandom_range(255));
        endcase
    endfunction

    function automatic req_t random_req(int ins_pct);
        logic [TAG_W-1:0] t;
        t = pick_tag();
        if ($urandom_range(99) < ins_pct) begin
            case ($urandom_range(3))
                0:       return make_req(ACT_FRONT, t, pick_prio());
                1:       return make_req(ACT_BACK, t, pick_prio());
                default: return make_req(ACT_SORTED, t, pick_prio());
            endcase
        end
        if (sb.count > 0 && $urandom_range(3) != 0)
            t = sb.tags[$urandom_range(sb.count - 1)];
        return make_req(ACT_REMOVE, t, pick_prio());
    endfunction

    task automatic send_req(req_t r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        int i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < n; i++)
            send_req(random_req(((i / 35) % 2 == 0) ? 80 : 30));
    endtask

    initial
    begin : stimulus
        int i;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(make_req(ACT_REMOVE, '0, '0));
        send_req(make_req(ACT_SORTED, '0, '0));
        send_req(make_req(ACT_FRONT, '1, '1));
        send_req(make_req(ACT_BACK, 32'hA5A5_A5A5, '0));
        send_req(make_req(ACT_SORTED, 32'h5A5A_5A5A, '1));
        send_req(make_req(ACT_SORTED, '0, INS_PRIO));
        send_req(make_req(ACT_REMOVE, '0, '0));
        send_req(make_req(ACT_REMOVE, 32'h1234_5678, '0));
        for (i = 0; i < 11; i++)
            send_req(make_req((i % 2) ? ACT_BACK : ACT_SORTED, TAG_W'(i + 100),
                              PRIO_W'(i * 23)));
        send_req(make_req(ACT_FRONT, 32'hDEAD_0001, '0));
        send_req(make_req(ACT_BACK, 32'hDEAD_0002, '0));
        send_req(make_req(ACT_SORTED, 32'hDEAD_0003, '1));
        send_req(make_req(ACT_REMOVE, '1, '0));

        run_phase(0, 0, 140);
        run_phase(70, 0, 140);
        run_phase(0, 70, 140);
        run_phase(17, 17, 140);

        // hold the result side and keep offering requests
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b1;
        for (i = 0; i < 40; i++)
            send_req(random_req(60));
        req_valid <= 1'b0;

        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results over four idle/stall mixes",
                 sb.requests, sb.checked);
        $display("and a long result hold-off: %0d removes hit, %0d inserts dropped, peak %0d.",
                 sb.hits, sb.drops, sb.peak);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/testbench.sv
